### rtl/rvde_pkg.sv
`default_nettype none

package rvde_pkg;

  // opcodes of the supported subset
  localparam logic [6:0] OPC_R    = 7'b0110011;
  localparam logic [6:0] OPC_I    = 7'b0010011;
  localparam logic [6:0] OPC_LOAD = 7'b0000011;
  localparam logic [6:0] OPC_JALR = 7'b1100111;
  localparam logic [6:0] OPC_S    = 7'b0100011;
  localparam logic [6:0] OPC_B    = 7'b1100011;
  localparam logic [6:0] OPC_U    = 7'b0110111;
  localparam logic [6:0] OPC_J    = 7'b1101111;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_SRA  = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  typedef enum logic [3:0] {
    CLS_R       = 4'd0,
    CLS_I       = 4'd1,
    CLS_LOAD    = 4'd2,
    CLS_JALR    = 4'd3,
    CLS_S       = 4'd4,
    CLS_B       = 4'd5,
    CLS_U       = 4'd6,
    CLS_J       = 4'd7,
    CLS_INVALID = 4'd8
  } cls_t;

  typedef enum logic [2:0] {
    ALUOP_ADD = 3'd0,
    ALUOP_SUB = 3'd1,
    ALUOP_R   = 3'd2,
    ALUOP_I   = 3'd3,
    ALUOP_LUI = 3'd4
  } alu_op_t;

  typedef struct packed {
    logic    reg_write;
    logic    mem_read;
    logic    mem_write;
    logic    mem_to_reg;
    logic    branch_flag;
    logic    alu_src;
    alu_op_t alu_op;
  } ctrl_t;

  typedef struct packed {
    logic        [31:0] instruction;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] alu_result;
    logic signed [31:0] imm_value;
    logic        [3:0]  instr_class;
    logic               reg_write;
    logic               mem_read;
    logic               mem_write;
    logic               mem_to_reg;
    logic               branch_flag;
    logic               alu_src;
    logic        [2:0]  alu_op;
    logic               invalid;
  } out_t;

endpackage

`default_nettype wire

### rtl/rv32_subset_decode_execute.sv
`default_nettype none

// rv32 subset decode and execute
// input channel: in_valid / in_ready / in_data carry one instruction word plus
// the two source register values per beat
// result channel: out_valid / out_ready / out_data carry the decoded control
// signals, the sign-extended immediate and the alu result, one beat per input
// pipeline: decode (class, controls, immediate) -> operand select ->
// alu and output register, three register stages
// throughput: one instruction per cycle while out_ready is high; every stage holds a valid bit and
// moves when the stage after it is empty or moving
// receiver stall: the output register holds its beat, stages fill behind it,
// in_ready drops only once all three stages are full; nothing is lost or
// repeated
// reset (rst_n low, synchronous): all valid bits clear, the pipeline is empty
// j and unknown opcodes come out with all controls, immediate and result zero
// and invalid set; unsupported funct3 for r or i gives result zero and invalid
module rv32_subset_decode_execute (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire rvde_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output rvde_pkg::out_t       out_data
);

  // ---------------------------------------------------------------- handshake
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_en, s2_en, out_en;

  // each stage loads when it is empty or its contents move on
  assign out_en   = !out_valid_r || out_ready;
  assign s2_en    = !s2_valid_r  || out_en;
  assign s1_en    = !s1_valid_r  || s2_en;
  assign in_ready = s1_en;
  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------- stage 1: decode
  logic [6:0]          opc;
  logic [31:0]         ins;
  rvde_pkg::cls_t      cls_nxt;
  rvde_pkg::ctrl_t     ctrl_nxt;
  logic signed [31:0]  imm_nxt;

  assign ins = in_data.instruction;
  assign opc = ins[6:0];

  always_comb begin
    ctrl_nxt = '0;
    ctrl_nxt.alu_op = rvde_pkg::ALUOP_ADD;
    case (opc)
      rvde_pkg::OPC_R: begin
        cls_nxt = rvde_pkg::CLS_R;
        ctrl_nxt.reg_write = 1'b1;
        ctrl_nxt.alu_op = rvde_pkg::ALUOP_R;
      end
      rvde_pkg::OPC_I: begin
        cls_nxt = rvde_pkg::CLS_I;
        ctrl_nxt.reg_write = 1'b1;
        ctrl_nxt.alu_src = 1'b1;
        ctrl_nxt.alu_op = rvde_pkg::ALUOP_I;
      end
      rvde_pkg::OPC_LOAD: begin
        cls_nxt = rvde_pkg::CLS_LOAD;
        ctrl_nxt.reg_write = 1'b1;
        ctrl_nxt.mem_read = 1'b1;
        ctrl_nxt.mem_to_reg = 1'b1;
        ctrl_nxt.alu_src = 1'b1;
      end
      rvde_pkg::OPC_JALR: begin
        cls_nxt = rvde_pkg::CLS_JALR;
        ctrl_nxt.reg_write = 1'b1;
        ctrl_nxt.branch_flag = 1'b1;
        ctrl_nxt.alu_src = 1'b1;
      end
      rvde_pkg::OPC_S: begin
        cls_nxt = rvde_pkg::CLS_S;
        ctrl_nxt.mem_write = 1'b1;
        ctrl_nxt.alu_src = 1'b1;
      end
      rvde_pkg::OPC_B: begin
        cls_nxt = rvde_pkg::CLS_B;
        ctrl_nxt.branch_flag = 1'b1;
        ctrl_nxt.alu_op = rvde_pkg::ALUOP_SUB;
      end
      rvde_pkg::OPC_U: begin
        cls_nxt = rvde_pkg::CLS_U;
        ctrl_nxt.reg_write = 1'b1;
        ctrl_nxt.alu_src = 1'b1;
        ctrl_nxt.alu_op = rvde_pkg::ALUOP_LUI;
      end
      rvde_pkg::OPC_J: begin
        cls_nxt = rvde_pkg::CLS_J;
      end
      default: begin
        cls_nxt = rvde_pkg::CLS_INVALID;
      end
    endcase
  end

  // immediate formats
  always_comb begin
    case (cls_nxt)
      rvde_pkg::CLS_I, rvde_pkg::CLS_LOAD, rvde_pkg::CLS_JALR:
        imm_nxt = {{20{ins[31]}}, ins[31:20]};
      rvde_pkg::CLS_S:
        imm_nxt = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      rvde_pkg::CLS_B:
        imm_nxt = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      rvde_pkg::CLS_U:
        imm_nxt = {ins[31:12], 12'h000};
      default:
        imm_nxt = '0;
    endcase
  end

  rvde_pkg::cls_t      s1_cls_r;
  rvde_pkg::ctrl_t     s1_ctrl_r;
  logic signed [31:0]  s1_imm_r;
  logic [2:0]          s1_f3_r;
  logic signed [31:0]  s1_rs1_r;
  logic signed [31:0]  s1_rs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_cls_r  <= cls_nxt;
      s1_ctrl_r <= ctrl_nxt;
      s1_imm_r  <= imm_nxt;
      s1_f3_r   <= ins[14:12];
      s1_rs1_r  <= in_data.rs1_value;
      s1_rs2_r  <= in_data.rs2_value;
    end
  end

  // ---------------------------------------------------------------- stage 2: operand select
  logic signed [31:0]  op2_nxt;
  assign op2_nxt = s1_ctrl_r.alu_src ? s1_imm_r : s1_rs2_r;

  rvde_pkg::cls_t      s2_cls_r;
  rvde_pkg::ctrl_t     s2_ctrl_r;
  logic signed [31:0]  s2_imm_r;
  logic [2:0]          s2_f3_r;
  logic signed [31:0]  s2_a_r;
  logic signed [31:0]  s2_b_r;
  logic                s2_opc_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_cls_r     <= s1_cls_r;
      s2_ctrl_r    <= s1_ctrl_r;
      s2_imm_r     <= s1_imm_r;
      s2_f3_r      <= s1_f3_r;
      s2_a_r       <= s1_rs1_r;
      s2_b_r       <= op2_nxt;
      s2_opc_bad_r <= (s1_cls_r == rvde_pkg::CLS_J) || (s1_cls_r == rvde_pkg::CLS_INVALID);
    end
  end

  // ---------------------------------------------------------------- stage 3: alu
  logic signed [31:0]  res_nxt;
  logic                bad_nxt;
  logic                ltu;

  assign ltu = $unsigned(s2_a_r) < $unsigned(s2_b_r);

  always_comb begin
    res_nxt = '0;
    bad_nxt = s2_opc_bad_r;
    if (!s2_opc_bad_r) begin
      case (s2_ctrl_r.alu_op)
        rvde_pkg::ALUOP_R: begin
          case (s2_f3_r)
            rvde_pkg::F3_ADD: res_nxt = s2_a_r + s2_b_r;
            rvde_pkg::F3_AND: res_nxt = s2_a_r & s2_b_r;
            rvde_pkg::F3_SRA: res_nxt = s2_a_r >>> s2_b_r[4:0];
            default:          bad_nxt = 1'b1;
          endcase
        end
        rvde_pkg::ALUOP_I: begin
          case (s2_f3_r)
            rvde_pkg::F3_ADD:  res_nxt = s2_a_r + s2_b_r;
            rvde_pkg::F3_OR:   res_nxt = s2_a_r | s2_b_r;
            rvde_pkg::F3_SLTU: res_nxt = {31'd0, ltu};
            default:           bad_nxt = 1'b1;
          endcase
        end
        rvde_pkg::ALUOP_ADD: res_nxt = s2_a_r + s2_b_r;
        rvde_pkg::ALUOP_SUB: res_nxt = s2_a_r - s2_b_r;
        rvde_pkg::ALUOP_LUI: res_nxt = s2_b_r;
        default:             res_nxt = '0;
      endcase
    end
  end

  rvde_pkg::out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_r.alu_result  <= res_nxt;
      out_r.imm_value   <= s2_imm_r;
      out_r.instr_class <= s2_cls_r;
      out_r.reg_write   <= s2_ctrl_r.reg_write;
      out_r.mem_read    <= s2_ctrl_r.mem_read;
      out_r.mem_write   <= s2_ctrl_r.mem_write;
      out_r.mem_to_reg  <= s2_ctrl_r.mem_to_reg;
      out_r.branch_flag <= s2_ctrl_r.branch_flag;
      out_r.alu_src     <= s2_ctrl_r.alu_src;
      out_r.alu_op      <= s2_ctrl_r.alu_op;
      out_r.invalid     <= bad_nxt;
    end
  end

  assign out_data = out_r;

  // ---------------------------------------------------------------- assertions
  // input is held off only when the whole pipeline is full and the receiver stalls
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low with room in the pipeline");

  // j and unknown opcodes leave every control, immediate and result at zero
  a_bad_opcode_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.instr_class == rvde_pkg::CLS_J ||
                   out_data.instr_class == rvde_pkg::CLS_INVALID)) |->
    (out_data.invalid && !out_data.reg_write && !out_data.mem_read &&
     !out_data.mem_write && !out_data.branch_flag && !out_data.alu_src &&
     out_data.alu_result == 32'sd0 && out_data.imm_value == 32'sd0))
    else $error("bad opcode left stale controls");

  // lui passes the immediate straight through the alu
  a_lui_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.instr_class == rvde_pkg::CLS_U) |->
    (out_data.alu_result == out_data.imm_value && !out_data.invalid))
    else $error("lui result differs from immediate");

  // an invalid beat always carries a zero result
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.invalid) |-> (out_data.alu_result == 32'sd0))
    else $error("invalid beat with nonzero result");

endmodule

`default_nettype wire
